[src/hdlp_pkg.sv]
package hdlp_pkg;

    // Scan phase codes
    localparam logic [3:0] PH_LEAD  = 4'd0;  // line start, skipping whitespace
    localparam logic [3:0] PH_ZERO  = 4'd1;  // saw '0', expect 'x'
    localparam logic [3:0] PH_ADDR  = 4'd2;  // collecting address digits
    localparam logic [3:0] PH_POSTA = 4'd3;  // after address, expect ':'
    localparam logic [3:0] PH_GAP   = 4'd4;  // whitespace between word tokens
    localparam logic [3:0] PH_TOKEN = 4'd5;  // collecting word digits
    localparam logic [3:0] PH_SKIP  = 4'd6;  // drop rest of line

    localparam logic [3:0]  WORD_DIGITS = 4'd8;
    localparam logic [63:0] ADDR_STEP   = 64'd4;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    typedef struct packed {
        logic [3:0]  phase;
        logic [3:0]  digit_count;
        logic [63:0] address;
        logic [31:0] word;
    } scan_state_t;

    typedef struct packed {
        logic        emit;
        logic [63:0] word_address;
        logic [31:0] word_value;
    } word_out_t;

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            r = {1'b1, c[3:0]};
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[src/hdlp_step.sv]
module hdlp_step (
    input  hdlp_pkg::scan_state_t cur,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_text,
    output hdlp_pkg::scan_state_t nxt,
    output hdlp_pkg::word_out_t   result
);

    logic       newline;
    logic       sp;
    logic [4:0] hx;
    logic       is_hex;
    logic [3:0] hv;

    assign newline = (text_byte == hdlp_pkg::CH_NEWLINE);
    assign sp      = hdlp_pkg::is_space(text_byte);
    assign hx      = hdlp_pkg::hex_decode(text_byte);
    assign is_hex  = hx[4];
    assign hv      = hx[3:0];

    always_comb begin
        hdlp_pkg::scan_state_t s;
        s = cur;
        result = '0;
        if (!newline) begin
            case (cur.phase)
                hdlp_pkg::PH_LEAD: begin
                    if (text_byte == hdlp_pkg::CH_ZERO) s.phase = hdlp_pkg::PH_ZERO;
                    else if (!sp) s.phase = hdlp_pkg::PH_SKIP;
                end
                hdlp_pkg::PH_ZERO: begin
                    if (text_byte == hdlp_pkg::CH_X) begin
                        s.phase       = hdlp_pkg::PH_ADDR;
                        s.digit_count = '0;
                        s.address     = '0;
                    end else begin
                        s.phase = hdlp_pkg::PH_SKIP;
                    end
                end
                hdlp_pkg::PH_ADDR: begin
                    if (is_hex) begin
                        s.address     = {cur.address[59:0], hv};
                        s.digit_count = cur.digit_count + 4'd1;
                        if (s.digit_count >= hdlp_pkg::WORD_DIGITS) s.phase = hdlp_pkg::PH_POSTA;
                    end else begin
                        s.phase = hdlp_pkg::PH_SKIP;
                    end
                end
                hdlp_pkg::PH_POSTA: begin
                    if (text_byte == hdlp_pkg::CH_COLON) s.phase = hdlp_pkg::PH_GAP;
                    else if (!sp) s.phase = hdlp_pkg::PH_SKIP;
                end
                hdlp_pkg::PH_GAP: begin
                    if (is_hex) begin
                        s.phase       = hdlp_pkg::PH_TOKEN;
                        s.word        = {28'd0, hv};
                        s.digit_count = 4'd1;
                    end else if (!sp) begin
                        s.phase = hdlp_pkg::PH_SKIP;
                    end
                end
                hdlp_pkg::PH_TOKEN: begin
                    if (is_hex) begin
                        if (cur.digit_count < hdlp_pkg::WORD_DIGITS) begin
                            s.word        = {cur.word[27:0], hv};
                            s.digit_count = cur.digit_count + 4'd1;
                        end else begin
                            s.phase = hdlp_pkg::PH_SKIP;
                        end
                    end else if (sp && (cur.digit_count == hdlp_pkg::WORD_DIGITS)) begin
                        result.emit         = 1'b1;
                        result.word_address = cur.address;
                        result.word_value   = cur.word;
                        s.address           = cur.address + hdlp_pkg::ADDR_STEP;
                        s.word              = '0;
                        s.digit_count       = '0;
                        s.phase             = hdlp_pkg::PH_GAP;
                    end else begin
                        s.phase = hdlp_pkg::PH_SKIP;
                    end
                end
                default: s.phase = hdlp_pkg::PH_SKIP;
            endcase
        end
        if (newline || end_of_text) begin
            // close a finished token on line end, then restart the line
            if ((s.phase == hdlp_pkg::PH_TOKEN) && (s.digit_count == hdlp_pkg::WORD_DIGITS)) begin
                result.emit         = 1'b1;
                result.word_address = s.address;
                result.word_value   = s.word;
            end
            s = '{phase: hdlp_pkg::PH_LEAD, digit_count: 4'd0, address: 64'd0, word: 32'd0};
        end
        nxt = s;
    end

endmodule

[src/hex_dump_line_parser.sv]
// hex_dump_line_parser: parse a text memory dump into (address, word) pairs.
//
// Input channel (s_axis_*): one ASCII byte per item in tdata[7:0]; tlast marks
// the last byte of the text and closes the current line after it. A newline
// also closes the line. Lines of the form  0xAAAAAAAA : WWWWWWWW WWWWWWWW ...
// produce one result item per 8-digit word token, the address advancing by 4.
// Result channel (m_axis_*): tdata[63:0] word address, tdata[95:64] word value.
//
// A result is registered and appears on m_axis in the cycle after the byte
// that closes its token is accepted. Throughput: one byte per cycle while the
// input is ready; the scan state updates in a single pass of logic between
// the state registers and the result register. The input stays ready while
// the result register is empty or being taken, so a stall on m_axis holds at
// most one result and back-pressures s_axis only while that result is waiting.
// Reset (aresetn low, synchronous): the scan returns to line start with zero
// address and word, and any pending result is dropped.
module hex_dump_line_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
    input  logic        s_axis_tlast,  // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata   // [63:0] word_address, [95:64] word_value
);

    hdlp_pkg::scan_state_t state_reg;
    hdlp_pkg::scan_state_t state_next;
    hdlp_pkg::word_out_t   step_out;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [95:0] m_data_reg;
    logic [95:0] m_data_next;
    logic        s_fire;

    // Accept while the result register is free or draining this cycle
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    hdlp_step u_step (
        .cur         (state_reg),
        .text_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .nxt         (state_next),
        .result      (step_out)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_fire) begin
            // load a new result or empty the register
            m_valid_next = step_out.emit;
            if (step_out.emit) begin
                m_data_next = {step_out.word_value, step_out.word_address};
            end
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{phase: hdlp_pkg::PH_LEAD, digit_count: 4'd0,
                             address: 64'd0, word: 32'd0};
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg <= state_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload register needs no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A line end always restarts the scan with a cleared address
    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_axis_tlast || (s_axis_tdata == hdlp_pkg::CH_NEWLINE)))
        |=> (state_reg.phase == hdlp_pkg::PH_LEAD) && (state_reg.address == 64'd0))
        else $error("scan did not restart after line end");

    // An emitted word leaves the scan between tokens or at line start
    a_emit_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && step_out.emit)
        |=> m_axis_tvalid && ((state_reg.phase == hdlp_pkg::PH_GAP) ||
                              (state_reg.phase == hdlp_pkg::PH_LEAD)))
        else $error("bad phase after emitted word");

    // Digit count never passes one word
    a_digit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg.digit_count <= hdlp_pkg::WORD_DIGITS))
        else $error("digit count overflow");

    // A token in progress holds at least one digit
    a_token_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == hdlp_pkg::PH_TOKEN) |-> (state_reg.digit_count != 4'd0))
        else $error("token phase with no digits");

endmodule

[bench/hex_dump_line_parser_tb.sv]
`timescale 1ns / 1ps

module hex_dump_line_parser_tb;

    // One parsed (address, word) pair as it leaves the result channel
    typedef struct packed {
        logic [63:0] address;
        logic [31:0] value;
    } dump_word_t;

    // Scoreboard: tracks the line scan in step with the block and holds the words
    // that the accepted text has produced but that have not come out yet.
    class dump_word_board;
        logic [3:0]  phase;
        logic [3:0]  ndig;
        logic [63:0] line_addr;
        logic [31:0] word_acc;
        dump_word_t  words_due[$];
        int unsigned mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            phase     = hdlp_pkg::PH_LEAD;
            ndig      = 4'd0;
            line_addr = 64'd0;
            word_acc  = 32'd0;
        endfunction

        function logic is_blank(logic [7:0] c);
            return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
        endfunction

        // Return the digit's value, or -1 for any other byte
        function int digit_value(logic [7:0] c);
            if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
            if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
            if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
            return -1;
        endfunction

        function void emit_word();
            dump_word_t w;
            w.address = line_addr;
            w.value   = word_acc;
            words_due.push_back(w);
            line_addr = line_addr + hdlp_pkg::ADDR_STEP;
            word_acc  = 32'd0;
            ndig      = 4'd0;
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            int   d;
            logic blank;
            logic nl;
            d     = digit_value(c);
            blank = is_blank(c);
            nl    = (c == hdlp_pkg::CH_NEWLINE);
            if (!nl) begin
                case (phase)
                    hdlp_pkg::PH_LEAD: begin
                        if (c == hdlp_pkg::CH_ZERO) phase = hdlp_pkg::PH_ZERO;
                        else if (!blank) phase = hdlp_pkg::PH_SKIP;
                    end
                    hdlp_pkg::PH_ZERO: begin
                        if (c == hdlp_pkg::CH_X) begin
                            phase     = hdlp_pkg::PH_ADDR;
                            ndig      = 4'd0;
                            line_addr = 64'd0;
                        end else begin
                            phase = hdlp_pkg::PH_SKIP;
                        end
                    end
                    hdlp_pkg::PH_ADDR: begin
                        if (d >= 0) begin
                            line_addr = {line_addr[59:0], d[3:0]};
                            ndig      = ndig + 4'd1;
                            if (ndig >= hdlp_pkg::WORD_DIGITS) phase = hdlp_pkg::PH_POSTA;
                        end else begin
                            phase = hdlp_pkg::PH_SKIP;
                        end
                    end
                    hdlp_pkg::PH_POSTA: begin
                        if (c == hdlp_pkg::CH_COLON) phase = hdlp_pkg::PH_GAP;
                        else if (!blank) phase = hdlp_pkg::PH_SKIP;
                    end
                    hdlp_pkg::PH_GAP: begin
                        if (d >= 0) begin
                            phase    = hdlp_pkg::PH_TOKEN;
                            word_acc = {28'd0, d[3:0]};
                            ndig     = 4'd1;
                        end else if (!blank) begin
                            phase = hdlp_pkg::PH_SKIP;
                        end
                    end
                    hdlp_pkg::PH_TOKEN: begin
                        if (d >= 0) begin
                            if (ndig < hdlp_pkg::WORD_DIGITS) begin
                                word_acc = {word_acc[27:0], d[3:0]};
                                ndig     = ndig + 4'd1;
                            end else begin
                                phase = hdlp_pkg::PH_SKIP;
                            end
                        end else if (blank && ndig == hdlp_pkg::WORD_DIGITS) begin
                            emit_word();
                            phase = hdlp_pkg::PH_GAP;
                        end else begin
                            phase = hdlp_pkg::PH_SKIP;
                        end
                    end
                    default: phase = hdlp_pkg::PH_SKIP;
                endcase
            end
            // Line end: a full token still open is closed here
            if (nl || last) begin
                if (phase == hdlp_pkg::PH_TOKEN && ndig == hdlp_pkg::WORD_DIGITS) emit_word();
                restart();
            end
        endfunction

        function void check_word(logic [95:0] data);
            dump_word_t w;
            if (words_due.size() == 0) begin
                $error("unexpected result: word_address %h word_value %h",
                       data[63:0], data[95:64]);
                mismatches++;
                return;
            end
            w = words_due.pop_front();
            if (data[63:0] !== w.address) begin
                $error("word_address: expected %h, actual %h", w.address, data[63:0]);
                mismatches++;
            end
            if (data[95:64] !== w.value) begin
                $error("word_value: expected %h, actual %h", w.value, data[95:64]);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] text_byte
    logic        s_axis_tlast  = 1'b0;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;           // [63:0] word_address, [95:64] word_value

    dump_word_board board;
    logic [7:0]     line_text[$];
    int unsigned    bytes_sent  = 0;
    int unsigned    tx_idle_pct = 0;
    int unsigned    rx_idle_pct = 0;
    bit             calm        = 1'b0;   // no idling on either side
    bit             hold_request = 1'b0;  // ask the receiver for one long hold-off
    bit             hold_done   = 1'b0;
    bit             drain_done  = 1'b0;

    hex_dump_line_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 aclk = ~aclk;

    // Sample both channels at the edge; drives change only through NBAs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) board.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
        end
    end

    // Offer one byte, with an optional idle burst first; return once it is taken
    task automatic send_byte(input logic [7:0] c, input logic last);
        int unsigned gap;
        if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Send the buffered line; end_of_text on its final byte when asked
    task automatic send_line(input logic last_at_end);
        for (int i = 0; i < line_text.size(); i++) begin
            send_byte(line_text[i], last_at_end && (i == line_text.size() - 1));
        end
        line_text.delete();
    endtask

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + {4'd0, v};
        return (upper ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
    endfunction

    // Eight digits, most significant first, each in a random case
    function automatic void push_hex(input logic [31:0] v);
        for (int i = 7; i >= 0; i--)
            line_text.push_back(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 7))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Build one line: mostly well-formed with random content, some corrupted,
    // some pure noise; then close it by newline, end_of_text, or both.
    task automatic send_random_line();
        int unsigned style;
        int unsigned ntok;
        int unsigned pos;
        int unsigned ending;
        logic [31:0] base;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(1, 12)) line_text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) line_text.push_back(blank_char());
            push_str("0x");
            base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 15)
                                               : $urandom();
            push_hex(base);
            repeat ($urandom_range(0, 1)) line_text.push_back(blank_char());
            line_text.push_back(hdlp_pkg::CH_COLON);
            ntok = $urandom_range(0, 5);
            for (int t = 0; t < ntok; t++) begin
                repeat ($urandom_range(t == 0 ? 0 : 1, 2)) line_text.push_back(blank_char());
                push_hex(pick_word());
            end
            repeat ($urandom_range(0, 1)) line_text.push_back(blank_char());
            // Break the line: overwrite one byte, or add one stray digit
            pos = $urandom_range(0, line_text.size() - 1);
            if (style == 1) line_text[pos] = 8'($urandom_range(0, 255));
            if (style == 2) line_text.insert(pos, hex_char(4'($urandom_range(0, 15)), 1'b0));
        end
        ending = $urandom_range(0, 5);
        if (ending == 0) begin
            send_line(1'b1);
        end else begin
            line_text.push_back(hdlp_pkg::CH_NEWLINE);
            send_line(ending == 1);
        end
    endtask

    // Hold off the sender until every pending word has come out
    task automatic wait_drained();
        while (board.words_due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 63) == 0) rx_idle_pct = 10 * $urandom_range(0, 3);
                @(posedge aclk);
            end
        end
    end

    initial begin
        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every kind of leading blank, lowest address, all-ones word ended by newline
        line_text.push_back(8'h09); line_text.push_back(8'h0B);
        line_text.push_back(8'h0C); line_text.push_back(8'h0D);
        push_str(" 0x00000000:ffffffff\n");
        send_line(1'b0);
        // Address carries past 32 bits; last token closed by end_of_text alone
        push_str("0xFFFFFFFC : 0123abcd ABCDEF89");
        send_line(1'b1);
        // Bad heads: short address, capital X, leading junk
        push_str("0x10:12345678\n0X00000000:11111111\nx0x00000000:11111111\n");
        send_line(1'b0);
        // Bad tokens: nine digits, seven digits, high byte and NUL glued to a word
        push_str("0x00000010: 123456789 22222222\n0x00000020:1234567 22222222\n");
        push_str("0x00000030:aaaaaaaa");
        line_text.push_back(8'h80);
        push_str("bbbbbbbb\n0x00000034:cccccccc");
        line_text.push_back(8'h00);
        line_text.push_back(hdlp_pkg::CH_NEWLINE);
        send_line(1'b0);
        // Head with nothing after the colon
        push_str("0x00000040:\n");
        send_line(1'b0);
        // Newline that also carries end_of_text closes the line once
        push_str("0x00000050: cafef00d\n");
        send_line(1'b1);
        // Blank before the colon, text ends on a trailing blank
        push_str("0x00000060\t:  12345678 ");
        send_line(1'b1);

        // Random part: long receiver hold-off and a full drain pause on the way
        while (bytes_sent < 1400) begin
            tx_idle_pct = 10 * $urandom_range(0, 3);
            if (!hold_done && bytes_sent > 400) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && bytes_sent > 800) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                drain_done = 1'b1;
            end
            if (bytes_sent > 1250) calm = 1'b1;
            send_random_line();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        wait_drained();
        repeat (10) @(posedge aclk);
        if (board.words_due.size() != 0) begin
            $error("%0d expected words never arrived", board.words_due.size());
            board.mismatches++;
        end
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
